[design/dbd_pkg.sv]
// Package for the days-between-dates unit: shared types, widths and constants.
// It also holds the calendar helpers (month length, leap year, year residue).
// No dependencies.
package dbd_pkg;

  // Field widths that the interface fixes.
  localparam int unsigned DAY_W   = 5;
  localparam int unsigned MONTH_W = 4;
  localparam int unsigned COUNT_W = 22;
  localparam int unsigned R400_W  = 9;

  // Largest count that the result field carries; longer spans saturate here.
  localparam logic [COUNT_W-1:0] COUNT_MAX = 22'd4194303;

  // Year residue by reciprocal multiplication: y / 400 is (y / 16) / 25, and
  // x / 25 equals (x * 83887) >> 21 for every x below 2^16 (years up to 20 bits).
  localparam int unsigned DIV_IN_W    = 16;
  localparam int unsigned RECIP_W     = 17;
  localparam int unsigned RECIP_SHIFT = 21;
  localparam int unsigned QUOT_W      = 12;
  localparam logic [RECIP_W-1:0] RECIP_25 = 17'd83887;

  // Calendar constants.
  localparam logic [R400_W:0]    LEAP_CYCLE   = 10'd400;
  localparam logic [R400_W-1:0]  CENTURY_1    = 9'd100;
  localparam logic [R400_W-1:0]  CENTURY_2    = 9'd200;
  localparam logic [R400_W-1:0]  CENTURY_3    = 9'd300;
  localparam logic [R400_W-1:0]  CYCLE_LAST   = 9'd399;
  localparam logic [MONTH_W-1:0] MONTH_JAN    = 4'd1;
  localparam logic [MONTH_W-1:0] MONTH_FEB    = 4'd2;
  localparam logic [MONTH_W-1:0] MONTH_DEC    = 4'd12;
  localparam logic [DAY_W-1:0]   DAY_FIRST    = 5'd1;
  localparam logic [DAY_W-1:0]   FEB_LEAP_LEN = 5'd29;

  // Day and month of one date.
  typedef struct packed {
    logic [DAY_W-1:0]   day;
    logic [MONTH_W-1:0] month;
  } md_t;

  // Status of the queue between the front and the back.
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  typedef enum logic [1:0] {
    FS_IDLE,
    FS_REDUCE,
    FS_PUSH
  } front_state_e;

  typedef enum logic [1:0] {
    BS_IDLE,
    BS_WALK,
    BS_DONE
  } back_state_e;

  // Quotient of a year by 400, given the year already divided by 16.
  function automatic logic [QUOT_W-1:0] quot400(input logic [DIV_IN_W-1:0] y_div16);
    logic [DIV_IN_W+RECIP_W-1:0] prod;
    prod = {{RECIP_W{1'b0}}, y_div16} * {{DIV_IN_W{1'b0}}, RECIP_25};
    return prod[RECIP_SHIFT +: QUOT_W];
  endfunction

  // Year modulo 400 from the low year bits and the quotient by 400.
  function automatic logic [R400_W-1:0] rem400(input logic [R400_W-1:0] y_low,
                                               input logic [QUOT_W-1:0] q);
    logic [QUOT_W-1:0] qm;
    qm = q * QUOT_W'(LEAP_CYCLE);
    return y_low - qm[R400_W-1:0];
  endfunction

  // Leap year from the two low year bits and the year modulo 400.
  function automatic logic is_leap(input logic [1:0] y_low,
                                   input logic [R400_W-1:0] r400);
    logic century;
    century = (r400 == CENTURY_1) || (r400 == CENTURY_2) || (r400 == CENTURY_3);
    return ((y_low == 2'd0) && !century) || (r400 == '0);
  endfunction

  // Length of a month; months outside the calendar have length zero.
  function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                 input logic leap);
    logic [DAY_W-1:0] len;
    case (m)
      4'd1:    len = 5'd31;
      4'd2:    len = leap ? FEB_LEAP_LEN : 5'd28;
      4'd3:    len = 5'd31;
      4'd4:    len = 5'd30;
      4'd5:    len = 5'd31;
      4'd6:    len = 5'd30;
      4'd7:    len = 5'd31;
      4'd8:    len = 5'd31;
      4'd9:    len = 5'd30;
      4'd10:   len = 5'd31;
      4'd11:   len = 5'd30;
      4'd12:   len = 5'd31;
      default: len = 5'd0;
    endcase
    return len;
  endfunction

endpackage

[design/dbd_front.sv]
// Front part of the days-between-dates unit: accepts an item, reduces both
// years modulo 400 by reciprocal multiplication, checks the dates and orders them.
// Depends on dbd_pkg.
module dbd_front #(
  parameter int unsigned YEAR_BITS = 14
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      push_i,
  output logic                      full_o,
  input  logic [dbd_pkg::DAY_W-1:0]   first_day_i,
  input  logic [dbd_pkg::MONTH_W-1:0] first_month_i,
  input  logic [YEAR_BITS-1:0]        first_year_i,
  input  logic [dbd_pkg::DAY_W-1:0]   second_day_i,
  input  logic [dbd_pkg::MONTH_W-1:0] second_month_i,
  input  logic [YEAR_BITS-1:0]        second_year_i,
  input  dbd_pkg::q_status_t          q_status_i,
  output logic                        q_push_o,
  output logic                        invalid_o,
  output dbd_pkg::md_t                start_md_o,
  output logic [YEAR_BITS-1:0]        start_year_o,
  output logic [dbd_pkg::R400_W-1:0]  start_r400_o,
  output dbd_pkg::md_t                end_md_o,
  output logic [YEAR_BITS-1:0]        end_year_o
);

  localparam int unsigned DIV_W = dbd_pkg::DIV_IN_W;
  localparam int unsigned RES_W = dbd_pkg::R400_W;

  dbd_pkg::front_state_e state_q, state_d;
  logic stage_q, stage_d;
  dbd_pkg::md_t md1_q, md2_q;
  logic [YEAR_BITS-1:0] y1_q, y2_q;
  logic [dbd_pkg::QUOT_W-1:0] q1_q, q1_d, q2_q, q2_d;
  logic [dbd_pkg::R400_W-1:0] r1_q, r1_d, r2_q, r2_d;
  logic accept;

  assign accept = push_i && (state_q == dbd_pkg::FS_IDLE);

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      dbd_pkg::FS_IDLE: begin
        if (push_i) state_d = dbd_pkg::FS_REDUCE;
      end
      dbd_pkg::FS_REDUCE: begin
        if (stage_q) state_d = dbd_pkg::FS_PUSH;
      end
      dbd_pkg::FS_PUSH: begin
        if (!q_status_i.full) state_d = dbd_pkg::FS_IDLE;
      end
      default: state_d = dbd_pkg::FS_IDLE;
    endcase
  end

  // Handshake outputs.
  always_comb begin
    full_o   = (state_q != dbd_pkg::FS_IDLE);
    q_push_o = (state_q == dbd_pkg::FS_PUSH) && !q_status_i.full;
  end

  // Year residue modulo 400: the quotient first, then the remainder.
  always_comb begin
    stage_d = stage_q;
    q1_d    = q1_q;
    q2_d    = q2_q;
    r1_d    = r1_q;
    r2_d    = r2_q;
    if (accept) begin
      stage_d = 1'b0;
    end else if (state_q == dbd_pkg::FS_REDUCE) begin
      stage_d = 1'b1;
      if (!stage_q) begin
        // Divide by 16 with a shift; the reciprocal then divides by 25.
        q1_d = dbd_pkg::quot400(DIV_W'(y1_q >> 4));
        q2_d = dbd_pkg::quot400(DIV_W'(y2_q >> 4));
      end else begin
        r1_d = dbd_pkg::rem400(RES_W'(y1_q), q1_q);
        r2_d = dbd_pkg::rem400(RES_W'(y2_q), q2_q);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= dbd_pkg::FS_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Item registers.
  always_ff @(posedge clk_i) begin
    stage_q <= stage_d;
    q1_q    <= q1_d;
    q2_q    <= q2_d;
    r1_q    <= r1_d;
    r2_q    <= r2_d;
    if (accept) begin
      md1_q.day   <= first_day_i;
      md1_q.month <= first_month_i;
      y1_q        <= first_year_i;
      md2_q.day   <= second_day_i;
      md2_q.month <= second_month_i;
      y2_q        <= second_year_i;
    end
  end

  // Date checks and ordering.
  logic [dbd_pkg::DAY_W-1:0] len1, len2;
  logic ok1, ok2, first_later;

  always_comb begin
    len1 = dbd_pkg::month_len(md1_q.month, dbd_pkg::is_leap(y1_q[1:0], r1_q));
    len2 = dbd_pkg::month_len(md2_q.month, dbd_pkg::is_leap(y2_q[1:0], r2_q));
    ok1  = (md1_q.day != '0) && (md1_q.day <= len1);
    ok2  = (md2_q.day != '0) && (md2_q.day <= len2);
    first_later = {y1_q, md1_q.month, md1_q.day} >= {y2_q, md2_q.month, md2_q.day};
    invalid_o = !(ok1 && ok2);
    if (first_later) begin
      start_md_o   = md2_q;
      start_year_o = y2_q;
      start_r400_o = r2_q;
      end_md_o     = md1_q;
      end_year_o   = y1_q;
    end else begin
      start_md_o   = md1_q;
      start_year_o = y1_q;
      start_r400_o = r1_q;
      end_md_o     = md2_q;
      end_year_o   = y2_q;
    end
  end

endmodule

[design/dbd_queue.sv]
// Two-entry queue that parts the front from the back of the unit.
// Depends on dbd_pkg.
module dbd_queue #(
  parameter int unsigned WIDTH = 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  logic [WIDTH-1:0]   wdata_i,
  input  logic               pop_i,
  output logic [WIDTH-1:0]   rdata_o,
  output dbd_pkg::q_status_t status_o
);

  logic [WIDTH-1:0] mem_q [2];
  logic wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  logic do_push, do_pop;

  assign status_o.full  = (cnt_q == 2'd2);
  assign status_o.empty = (cnt_q == 2'd0);
  assign do_push = push_i && !status_o.full;
  assign do_pop  = pop_i && !status_o.empty;
  assign rdata_o = mem_q[rd_ptr_q];

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (do_push) wr_ptr_q <= ~wr_ptr_q;
      if (do_pop) rd_ptr_q <= ~rd_ptr_q;
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= wdata_i;
  end

endmodule

[design/dbd_back.sv]
// Back part of the days-between-dates unit: walks the earlier date of a valid item
// forward one day a cycle until it meets the later one, then holds the result item.
// Depends on dbd_pkg.
module dbd_back #(
  parameter int unsigned YEAR_BITS = 14
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  dbd_pkg::q_status_t          q_status_i,
  output logic                        q_pop_o,
  input  logic                        invalid_i,
  input  dbd_pkg::md_t                start_md_i,
  input  logic [YEAR_BITS-1:0]        start_year_i,
  input  logic [dbd_pkg::R400_W-1:0]  start_r400_i,
  input  dbd_pkg::md_t                end_md_i,
  input  logic [YEAR_BITS-1:0]        end_year_i,
  output logic                        empty_o,
  input  logic                        pop_i,
  output logic [dbd_pkg::COUNT_W-1:0] day_count_o,
  output logic                        date_invalid_o
);

  dbd_pkg::back_state_e state_q, state_d;
  dbd_pkg::md_t cur_md_q, end_md_q;
  logic [YEAR_BITS-1:0] cur_year_q, end_year_q;
  logic [dbd_pkg::R400_W-1:0] cur_r400_q;
  logic [dbd_pkg::COUNT_W-1:0] count_q;
  logic invalid_q;
  logic at_end, load;

  assign at_end = (cur_md_q == end_md_q) && (cur_year_q == end_year_q);

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      dbd_pkg::BS_IDLE: begin
        if (!q_status_i.empty) begin
          state_d = invalid_i ? dbd_pkg::BS_DONE : dbd_pkg::BS_WALK;
        end
      end
      dbd_pkg::BS_WALK: begin
        if (at_end) state_d = dbd_pkg::BS_DONE;
      end
      dbd_pkg::BS_DONE: begin
        if (pop_i) state_d = dbd_pkg::BS_IDLE;
      end
      default: state_d = dbd_pkg::BS_IDLE;
    endcase
  end

  // Handshake outputs.
  always_comb begin
    q_pop_o = (state_q == dbd_pkg::BS_IDLE) && !q_status_i.empty;
    empty_o = (state_q != dbd_pkg::BS_DONE);
  end

  assign load = q_pop_o;
  assign day_count_o    = count_q;
  assign date_invalid_o = invalid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= dbd_pkg::BS_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next date after the cursor.
  logic [dbd_pkg::DAY_W-1:0] len;
  dbd_pkg::md_t next_md;
  logic [YEAR_BITS-1:0] next_year;
  logic [dbd_pkg::R400_W-1:0] next_r400;

  always_comb begin
    len = dbd_pkg::month_len(cur_md_q.month,
                             dbd_pkg::is_leap(cur_year_q[1:0], cur_r400_q));
    next_md   = cur_md_q;
    next_year = cur_year_q;
    next_r400 = cur_r400_q;
    if (cur_md_q.day == len) begin
      next_md.day = dbd_pkg::DAY_FIRST;
      if (cur_md_q.month == dbd_pkg::MONTH_DEC) begin
        next_md.month = dbd_pkg::MONTH_JAN;
        next_year     = cur_year_q + 1'b1;
        next_r400     = (cur_r400_q == dbd_pkg::CYCLE_LAST) ? '0 : cur_r400_q + 1'b1;
      end else begin
        next_md.month = cur_md_q.month + 1'b1;
      end
    end else begin
      next_md.day = cur_md_q.day + 1'b1;
    end
  end

  // Cursor and result registers.
  always_ff @(posedge clk_i) begin
    if (load) begin
      cur_md_q   <= start_md_i;
      cur_year_q <= start_year_i;
      cur_r400_q <= start_r400_i;
      end_md_q   <= end_md_i;
      end_year_q <= end_year_i;
      count_q    <= '0;
      invalid_q  <= invalid_i;
    end else if ((state_q == dbd_pkg::BS_WALK) && !at_end) begin
      cur_md_q   <= next_md;
      cur_year_q <= next_year;
      cur_r400_q <= next_r400;
      if (count_q != dbd_pkg::COUNT_MAX) count_q <= count_q + 1'b1;
    end
  end

endmodule

[design/days_between_dates_unit.sv]
// Days between two Gregorian dates, one result item for each input item.
// Each item passes the front (year residue, then the date check and the push into the queue),
// then the back loads it into the day walker, walks it one day per step and sees the end date.
// The front can take a new item while the back still walks an earlier one;
// an invalid item skips the walk.
// Reset is asynchronous and active low; it empties the queue and idles both parts.
module days_between_dates_unit #(
  parameter int unsigned YEAR_BITS = 14
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        push,
  output logic                        full,
  input  logic [dbd_pkg::DAY_W-1:0]   first_day_i,
  input  logic [dbd_pkg::MONTH_W-1:0] first_month_i,
  input  logic [YEAR_BITS-1:0]        first_year_i,
  input  logic [dbd_pkg::DAY_W-1:0]   second_day_i,
  input  logic [dbd_pkg::MONTH_W-1:0] second_month_i,
  input  logic [YEAR_BITS-1:0]        second_year_i,
  output logic                        empty,
  input  logic                        pop,
  output logic [dbd_pkg::COUNT_W-1:0] day_count_o,
  output logic                        date_invalid_o
);

  localparam int unsigned MD_W    = $bits(dbd_pkg::md_t);
  localparam int unsigned ENTRY_W = 1 + 2 * MD_W + 2 * YEAR_BITS + dbd_pkg::R400_W;

  dbd_pkg::q_status_t q_status;
  logic q_push, q_pop;
  logic [ENTRY_W-1:0] q_wdata, q_rdata;

  logic f_invalid, b_invalid;
  dbd_pkg::md_t f_start_md, f_end_md, b_start_md, b_end_md;
  logic [YEAR_BITS-1:0] f_start_year, f_end_year, b_start_year, b_end_year;
  logic [dbd_pkg::R400_W-1:0] f_start_r400, b_start_r400;

  // Front: accept, reduce and classify.
  dbd_front #(.YEAR_BITS(YEAR_BITS)) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push_i         (push),
    .full_o         (full),
    .first_day_i    (first_day_i),
    .first_month_i  (first_month_i),
    .first_year_i   (first_year_i),
    .second_day_i   (second_day_i),
    .second_month_i (second_month_i),
    .second_year_i  (second_year_i),
    .q_status_i     (q_status),
    .q_push_o       (q_push),
    .invalid_o      (f_invalid),
    .start_md_o     (f_start_md),
    .start_year_o   (f_start_year),
    .start_r400_o   (f_start_r400),
    .end_md_o       (f_end_md),
    .end_year_o     (f_end_year)
  );

  // Queue entries carry one classified item.
  assign q_wdata = {f_invalid, f_start_md, f_start_year, f_start_r400, f_end_md, f_end_year};
  assign {b_invalid, b_start_md, b_start_year, b_start_r400, b_end_md, b_end_year} = q_rdata;

  dbd_queue #(.WIDTH(ENTRY_W)) u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (q_push),
    .wdata_i  (q_wdata),
    .pop_i    (q_pop),
    .rdata_o  (q_rdata),
    .status_o (q_status)
  );

  // Back: day walker and result register.
  dbd_back #(.YEAR_BITS(YEAR_BITS)) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_status_i     (q_status),
    .q_pop_o        (q_pop),
    .invalid_i      (b_invalid),
    .start_md_i     (b_start_md),
    .start_year_i   (b_start_year),
    .start_r400_i   (b_start_r400),
    .end_md_i       (b_end_md),
    .end_year_i     (b_end_year),
    .empty_o        (empty),
    .pop_i          (pop),
    .day_count_o    (day_count_o),
    .date_invalid_o (date_invalid_o)
  );

  // An invalid result always carries a zero count.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && date_invalid_o) |-> (day_count_o == '0))
    else $error("invalid result with a non-zero count");

  // The front never pushes into a full queue.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push |-> !q_status.full)
    else $error("push into a full queue");

  // An accepted item keeps the front busy in the following cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !full) |=> full)
    else $error("front took an item without going busy");

endmodule
